FILE: hw/rtl/yta_pkg.sv
package yta_pkg;

  // Field and datapath widths
  localparam int unsigned WordW = 16;
  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW  = 32;
  localparam int unsigned SumW  = 19;

  // Product widths for each constant coefficient over an 8-bit operand
  localparam int unsigned PyW  = 17;  // 298 * y
  localparam int unsigned PrW  = 17;  // 409 * cr
  localparam int unsigned PgbW = 15;  // 100 * cb
  localparam int unsigned PgrW = 16;  // 208 * cr
  localparam int unsigned PbW  = 18;  // 516 * cb

  // BT.601 coefficients scaled by 256
  localparam logic [PyW-1:0]  COEF_Y  = PyW'(298);
  localparam logic [PrW-1:0]  COEF_RV = PrW'(409);
  localparam logic [PgbW-1:0] COEF_GU = PgbW'(100);
  localparam logic [PgrW-1:0] COEF_GV = PgrW'(208);
  localparam logic [PbW-1:0]  COEF_BU = PbW'(516);

  // Offsets with rounding folded in
  localparam logic [SumW-1:0] OFS_Y = SumW'(56992);
  localparam logic [SumW-1:0] OFS_G = SumW'(91776);
  localparam logic [SumW-1:0] OFS_B = SumW'(13696);

  localparam logic [ChanW-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [PixW-1:0]  PIX_BORDER   = '0;

  // Pixel issue phase within one pair
  typedef enum logic [2:0] {
    PH_BORDER = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_e;

  // One pixel conversion request
  typedef struct packed {
    logic             border;
    logic             last;
    logic [ChanW-1:0] y;
    logic [ChanW-1:0] cb;
    logic [ChanW-1:0] cr;
  } pix_req_t;

  // Clamp a two's complement channel sum to 8 bits
  function automatic logic [ChanW-1:0] clamp_chan(input logic [SumW-1:0] s);
    if (s[SumW-1]) begin
      return '0;
    end
    if (s[SumW-2:2*ChanW] != '0) begin
      return '1;
    end
    return s[2*ChanW-1:ChanW];
  endfunction

endpackage

FILE: hw/rtl/yuy2_to_argb_converter.sv
// Channel   Dir  Width  Contents
// s_axis    in   32+1   tdata: first_word, second_word; tuser: row_start
// m_axis    out  32+1   tdata: pixel; tlast: last_of_item
// cfg       in   1      border_enable
//
// One pixel leaves per cycle while m_axis is ready: a pair gives two pixels,
// three when it starts a row with border filling on; the pair register issuing
// one pixel a cycle sets this. A pair reaches its first pixel through the pair
// register, products, sums and clamp/output register.
// Reset is asynchronous, active low; it empties all stages and clears
// border_enable. Backpressure on m_axis ripples back stage by stage; no pixel
// is dropped or repeated.
module yuy2_to_argb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] first_word, [31:16] second_word
  input  logic [0:0]  s_axis_tuser,   // [0] row_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pixel
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic              border_en_q;
  logic              req_valid, req_ready;
  yta_pkg::pix_req_t req;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      border_en_q <= cfg_data_i;
    end
  end

  yta_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .border_en_i   (border_en_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .first_word_i  (s_axis_tdata[15:0]),
    .second_word_i (s_axis_tdata[31:16]),
    .row_start_i   (s_axis_tuser[0]),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  yta_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .pix_valid_o (m_axis_tvalid),
    .pix_ready_i (m_axis_tready),
    .pix_o       (m_axis_tdata),
    .pix_last_o  (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/yta_split.sv
module yta_split (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           border_en_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [yta_pkg::WordW-1:0]      first_word_i,
  input  logic [yta_pkg::WordW-1:0]      second_word_i,
  input  logic                           row_start_i,
  output logic                           req_valid_o,
  input  logic                           req_ready_i,
  output yta_pkg::pix_req_t              req_o
);

  logic                      valid_q, valid_d;
  yta_pkg::phase_e           phase_q, phase_d;
  logic [yta_pkg::WordW-1:0] w0_q, w1_q;
  logic                      req_fire;
  logic                      in_accept;

  assign req_fire   = valid_q && req_ready_i;
  assign in_ready_o = !valid_q || (req_fire && (phase_q == yta_pkg::PH_SECOND));
  assign in_accept  = in_valid_i && in_ready_o;

  // Advance through the pixels of the held pair, load a new pair
  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (req_fire) begin
      unique case (phase_q)
        yta_pkg::PH_BORDER: phase_d = yta_pkg::PH_FIRST;
        yta_pkg::PH_FIRST:  phase_d = yta_pkg::PH_SECOND;
        yta_pkg::PH_SECOND: valid_d = 1'b0;
        default:            valid_d = 1'b0;
      endcase
    end
    if (in_accept) begin
      valid_d = 1'b1;
      phase_d = (border_en_i && row_start_i) ? yta_pkg::PH_BORDER : yta_pkg::PH_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= yta_pkg::PH_FIRST;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Hold the pair words
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      w0_q <= first_word_i;
      w1_q <= second_word_i;
    end
  end

  // Build the request for the current phase
  always_comb begin
    req_o.cb     = w0_q[yta_pkg::ChanW-1:0];
    req_o.cr     = w1_q[yta_pkg::ChanW-1:0];
    req_o.border = 1'b0;
    req_o.last   = 1'b0;
    req_o.y      = w0_q[yta_pkg::WordW-1:yta_pkg::ChanW];
    unique case (phase_q)
      yta_pkg::PH_BORDER: req_o.border = 1'b1;
      yta_pkg::PH_FIRST:  req_o.last   = 1'b0;
      yta_pkg::PH_SECOND: begin
        req_o.last = 1'b1;
        req_o.y    = w1_q[yta_pkg::WordW-1:yta_pkg::ChanW];
      end
      default:            req_o.border = 1'b0;
    endcase
  end

  assign req_valid_o = valid_q;

  // A finished pair with no new one behind it leaves the stage empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (phase_q == yta_pkg::PH_SECOND) && !in_accept |=> !valid_q)
    else $error("pair stage did not drain after its second pixel");

  // A border row start issues the border pixel first
  a_border_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && border_en_i && row_start_i |=> valid_q && req_o.border)
    else $error("border pixel missing at row start");

endmodule

FILE: hw/rtl/yta_pipe.sv
module yta_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  yta_pkg::pix_req_t         req_i,
  output logic                      pix_valid_o,
  input  logic                      pix_ready_i,
  output logic [yta_pkg::PixW-1:0]  pix_o,
  output logic                      pix_last_o
);

  // Stage valid bits and ready chain
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3        = !v3_q || pix_ready_i;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign req_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: coefficient products
  logic [yta_pkg::PyW-1:0]  py_q;
  logic [yta_pkg::PrW-1:0]  pr_q;
  logic [yta_pkg::PgbW-1:0] pgb_q;
  logic [yta_pkg::PgrW-1:0] pgr_q;
  logic [yta_pkg::PbW-1:0]  pb_q;
  logic                     border1_q, last1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_valid_i) begin
      py_q      <= yta_pkg::PyW'(req_i.y) * yta_pkg::COEF_Y;
      pr_q      <= yta_pkg::PrW'(req_i.cr) * yta_pkg::COEF_RV;
      pgb_q     <= yta_pkg::PgbW'(req_i.cb) * yta_pkg::COEF_GU;
      pgr_q     <= yta_pkg::PgrW'(req_i.cr) * yta_pkg::COEF_GV;
      pb_q      <= yta_pkg::PbW'(req_i.cb) * yta_pkg::COEF_BU;
      border1_q <= req_i.border;
      last1_q   <= req_i.last;
    end
  end

  // Stage 2: channel sums in two's complement
  logic [yta_pkg::SumW-1:0] base, sum_r_d, sum_g_d, sum_b_d;
  logic [yta_pkg::SumW-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic                     border2_q, last2_q;

  always_comb begin
    base    = yta_pkg::SumW'(py_q) - yta_pkg::OFS_Y;
    sum_r_d = base + yta_pkg::SumW'(pr_q);
    sum_g_d = base - yta_pkg::SumW'(pgb_q) - yta_pkg::SumW'(pgr_q) + yta_pkg::OFS_G;
    sum_b_d = base + yta_pkg::SumW'(pb_q) - yta_pkg::OFS_B;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sum_r_q   <= sum_r_d;
      sum_g_q   <= sum_g_d;
      sum_b_q   <= sum_b_d;
      border2_q <= border1_q;
      last2_q   <= last1_q;
    end
  end

  // Stage 3: clamp, pack and hold for the output request
  logic [yta_pkg::PixW-1:0] pix_d, pix_q;
  logic                     last3_q;

  always_comb begin
    if (border2_q) begin
      pix_d = yta_pkg::PIX_BORDER;
    end else begin
      pix_d = {yta_pkg::ALPHA_OPAQUE, yta_pkg::clamp_chan(sum_r_q),
               yta_pkg::clamp_chan(sum_g_q), yta_pkg::clamp_chan(sum_b_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pix_q   <= pix_d;
      last3_q <= last2_q;
    end
  end

  assign pix_valid_o = v3_q;
  assign pix_o       = pix_q;
  assign pix_last_o  = last3_q;

  // A border pixel never closes an item
  a_border_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (pix_q == yta_pkg::PIX_BORDER) |-> !last3_q)
    else $error("border pixel flagged as last of item");

  // A stalled middle stage keeps its pixel
  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q)
    else $error("sum stage lost a pixel while stalled");

endmodule

FILE: tb/sv/yuy2_to_argb_converter_tb.sv
module yuy2_to_argb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output pixel
  typedef struct {
    logic [31:0] pixel;
    logic        last;
  } argb_pix_t;

  // Predict ARGB pixels from YUY2 pair requests and compare against the output stream
  class argb_predictor;
    argb_pix_t expected_pixels[$];
    bit        border_en;
    int        errors;

    function new();
      border_en = 1'b0;
      errors    = 0;
    endfunction

    function void set_border(bit en);
      border_en = en;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Saturate a scaled channel sum to one byte
    function logic [7:0] clamp8(int s);
      if (s < 0) begin
        return 8'h00;
      end
      if (s > 65535) begin
        return 8'hFF;
      end
      return s[15:8];
    endfunction

    // BT.601 conversion, coefficients scaled by 256
    function logic [31:0] convert(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
      int yi, cbi, cri, base, r, g, b;
      yi   = y;
      cbi  = cb;
      cri  = cr;
      base = 298 * yi - 56992;
      r    = base + 409 * cri;
      g    = base - 100 * cbi - 208 * cri + 91776;
      b    = base + 516 * cbi - 13696;
      return {yta_pkg::ALPHA_OPAQUE, clamp8(r), clamp8(g), clamp8(b)};
    endfunction

    // Queue the pixels caused by one accepted pair request
    function void note_pair(logic [15:0] w0, logic [15:0] w1, logic row_start);
      argb_pix_t p;
      if (border_en && row_start) begin
        p.pixel = yta_pkg::PIX_BORDER;
        p.last  = 1'b0;
        expected_pixels.push_back(p);
      end
      p.pixel = convert(w0[15:8], w0[7:0], w1[7:0]);
      p.last  = 1'b0;
      expected_pixels.push_back(p);
      p.pixel = convert(w1[15:8], w0[7:0], w1[7:0]);
      p.last  = 1'b1;
      expected_pixels.push_back(p);
    endfunction

    // Compare one accepted output pixel with the oldest expectation
    function void check_pixel(logic [31:0] pixel, logic last);
      argb_pix_t exp_pix;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel %h (last_of_item %b)", pixel, last);
        errors++;
        return;
      end
      exp_pix = expected_pixels.pop_front();
      if (pixel !== exp_pix.pixel) begin
        $error("pixel: expected %h, actual %h", exp_pix.pixel, pixel);
        errors++;
      end
      if (last !== exp_pix.last) begin
        $error("last_of_item: expected %b, actual %b", exp_pix.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;

  argb_predictor argb_pred = new();
  bit            src_calm  = 1'b0;
  bit            sink_calm = 1'b0;
  int            sink_hold = 0;

  yuy2_to_argb_converter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] first_word, [31:16] second_word
    .s_axis_tuser  (s_axis_tuser),   // [0] row_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] pixel
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short stalls, a few long ones
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Bias bytes toward the clamp edges and video black/white levels
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      2: begin
        return 8'($urandom_range(0, 31));
      end
      3: begin
        return 8'($urandom_range(224, 255));
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Throttle the output side
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = stall_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Observe accepted requests and pixels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        argb_pred.note_pair(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser[0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        argb_pred.check_pixel(m_axis_tdata, m_axis_tlast);
      end
    end
  end

  // Offer one pair request, with an optional gap in front, and hold until taken
  task automatic send_pair(input logic [15:0] w0, input logic [15:0] w1, input logic rs);
    int gap;
    gap = 0;
    if (!src_calm && $urandom_range(0, 2) == 0) begin
      gap = stall_len();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w1, w0};
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_bytes(input logic [7:0] y0, input logic [7:0] y1,
                            input logic [7:0] cb, input logic [7:0] cr, input logic rs);
    send_pair({y0, cb}, {y1, cr}, rs);
  endtask

  // Drop valid and wait until every expected pixel has left
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (argb_pred.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_border(input bit en);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    argb_pred.set_border(en);
  endtask

  initial begin
    bit border_plan[5];
    int sent;
    int row_len;
    logic rs;

    border_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes and reference colors with border filling off
    send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_bytes(8'd16, 8'd235, 8'd128, 8'd128, 1'b1);
    send_bytes(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_bytes(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_bytes(8'd81, 8'd145, 8'd90, 8'd240, 1'b0);
    send_bytes(8'd41, 8'd128, 8'd240, 8'd110, 1'b1);
    send_bytes(8'd128, 8'd128, 8'h00, 8'h00, 1'b0);
    send_bytes(8'd128, 8'd128, 8'hFF, 8'hFF, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    drain();

    // Directed: border pixels ahead of row starts
    write_border(1'b1);
    send_bytes(8'd16, 8'd235, 8'd128, 8'd128, 1'b1);
    send_bytes(8'd100, 8'd200, 8'd50, 8'd60, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    drain();
    write_border(1'b0);

    // Random rows, cycling through border settings and idle patterns
    for (int p = 0; p < 5; p++) begin
      write_border(border_plan[p]);
      src_calm  = (p == 1);
      sink_calm = (p == 1 || p == 3);
      sent = 0;
      while (sent < 60) begin
        row_len = $urandom_range(1, 6);
        for (int i = 0; i < row_len; i++) begin
          rs = (i == 0);
          if ($urandom_range(0, 9) == 0) begin
            rs = 1'($urandom_range(0, 1));
          end
          if ($urandom_range(0, 3) == 0) begin
            send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), rs);
          end else begin
            send_bytes(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rs);
          end
          sent++;
        end
      end
      drain();
    end

    sink_calm = 1'b0;
    repeat (20) @(posedge clk_i);
    if (argb_pred.errors == 0 && argb_pred.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
